FILE: design/dsmef_pkg.sv
// Shared types and constants for the dual sensor median and EMA filter.
package dsmef_pkg;

  localparam int VALUE_W = 16;
  localparam int OFS_W   = 11;
  localparam int TIME_W  = 32;
  localparam int NCHAN   = 4;
  localparam int IDX_W   = $clog2(NCHAN);

  // EMA weights: alpha = 77/256, rounding constant half an LSB
  localparam int ACC_W = VALUE_W + 10;
  localparam logic signed [ACC_W-1:0] EMA_NEW = ACC_W'(77);
  localparam logic signed [ACC_W-1:0] EMA_OLD = ACC_W'(179);
  localparam logic signed [ACC_W-1:0] EMA_RND = ACC_W'(128);

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_BOTTOM_TEMP_OFS = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_BOTTOM_HUM_OFS  = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_TOP_TEMP_OFS    = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_TOP_HUM_OFS     = IDX_W'(3);

  // mode codes
  localparam logic MODE_BEGIN  = 1'b0;
  localparam logic MODE_UPDATE = 1'b1;

  // control source codes
  localparam logic [1:0] SRC_NONE   = 2'd0;
  localparam logic [1:0] SRC_BOTTOM = 2'd1;
  localparam logic [1:0] SRC_TOP    = 2'd2;

  typedef struct packed {
    logic                      mode;
    logic [TIME_W-1:0]         now_ms;
    logic                      bottom_ok;
    logic signed [VALUE_W-1:0] bottom_temp;
    logic signed [VALUE_W-1:0] bottom_humidity;
    logic                      top_ok;
    logic signed [VALUE_W-1:0] top_temp;
    logic signed [VALUE_W-1:0] top_humidity;
  } req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] bottom_temp_smooth;
    logic signed [VALUE_W-1:0] bottom_humidity_smooth;
    logic                      bottom_valid;
    logic signed [VALUE_W-1:0] top_temp_smooth;
    logic signed [VALUE_W-1:0] top_humidity_smooth;
    logic                      top_valid;
    logic [1:0]                control_source;
    logic [TIME_W-1:0]         invalid_duration_ms;
  } res_t;

  // per-channel control for one request
  typedef struct packed {
    logic commit;   // request is processed this cycle
    logic start;    // begin mode: clear everything
    logic ok;       // sensor reading valid
  } chan_ctl_t;

endpackage

FILE: design/dsmef_chan.sv
// One filter channel: offset with saturation, median-of-3 window, EMA.
module dsmef_chan (
  input  logic                               clk,
  input  logic                               rst,
  input  dsmef_pkg::chan_ctl_t               ctl,
  input  logic signed [dsmef_pkg::VALUE_W-1:0] sample,
  input  logic signed [dsmef_pkg::OFS_W-1:0]   offset,
  output logic signed [dsmef_pkg::VALUE_W-1:0] smooth
);
  import dsmef_pkg::*;

  localparam logic signed [VALUE_W-1:0] VMAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VMIN = {1'b1, {(VALUE_W-1){1'b0}}};

  logic signed [VALUE_W-1:0] win [3];
  logic [1:0]                wpos, wpos_next;
  logic [1:0]                fill, fill_next;
  logic                      started, started_next;
  logic signed [VALUE_W-1:0] avg, avg_next;

  logic signed [VALUE_W:0]   sum;
  logic signed [VALUE_W-1:0] v;
  logic signed [VALUE_W-1:0] e0, e1, e2, mid, med, ema;
  logic signed [ACC_W-1:0]   acc;

  function automatic logic signed [VALUE_W-1:0] mid3(
    input logic signed [VALUE_W-1:0] a,
    input logic signed [VALUE_W-1:0] b,
    input logic signed [VALUE_W-1:0] c
  );
    logic signed [VALUE_W-1:0] lo, hi, t;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    t  = (hi < c) ? hi : c;
    return (lo > t) ? lo : t;
  endfunction

  always_comb begin
    sum = {sample[VALUE_W-1], sample} +
          {{(VALUE_W+1-OFS_W){offset[OFS_W-1]}}, offset};
    if (sum[VALUE_W] != sum[VALUE_W-1]) begin
      v = sum[VALUE_W] ? VMIN : VMAX;
    end else begin
      v = sum[VALUE_W-1:0];
    end
    // window as it stands after the new sample is written
    e0 = (wpos == 2'd0) ? v : win[0];
    e1 = (wpos == 2'd1) ? v : win[1];
    e2 = (wpos == 2'd2) ? v : win[2];
    mid = mid3(e0, e1, e2);
    med = (fill < 2'd2) ? v : mid;
    acc = EMA_NEW * ACC_W'(med) + EMA_OLD * ACC_W'(avg) + EMA_RND;
    ema = acc[VALUE_W+7:8];
  end

  always_comb begin
    wpos_next    = wpos;
    fill_next    = fill;
    started_next = started;
    avg_next     = avg;
    if (ctl.start) begin
      wpos_next    = 2'd0;
      fill_next    = 2'd0;
      started_next = 1'b0;
      avg_next     = '0;
    end else if (!ctl.ok) begin
      wpos_next    = 2'd0;
      fill_next    = 2'd0;
      started_next = 1'b0;
    end else begin
      wpos_next    = (wpos == 2'd2) ? 2'd0 : wpos + 2'd1;
      fill_next    = (fill == 2'd3) ? fill : fill + 2'd1;
      started_next = 1'b1;
      avg_next     = started ? ema : med;
    end
  end

  assign smooth = avg_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      wpos    <= 2'd0;
      fill    <= 2'd0;
      started <= 1'b0;
      avg     <= '0;
    end else if (ctl.commit) begin
      wpos    <= wpos_next;
      fill    <= fill_next;
      started <= started_next;
      avg     <= avg_next;
    end
  end

  // sample store, no reset: only entries written since the last clear are read
  always_ff @(posedge clk) begin
    if (ctl.commit && !ctl.start && ctl.ok) begin
      case (wpos)
        2'd0:    win[0] <= v;
        2'd1:    win[1] <= v;
        2'd2:    win[2] <= v;
        default: win[0] <= win[0];
      endcase
    end
  end

endmodule

FILE: design/dual_sensor_median_ema_filter.sv
// Top level of the dual sensor median-of-3 and EMA filter.
//
//  port group    direction  handshake           payload
//  in_*          request    in_valid/in_stall   in_data  (req_t)
//  out_*         result     out_valid/out_stall out_data (res_t)
//  cfg_*         write      cfg_we              cfg_index, cfg_data
//
// One request per cycle sustained while out_stall is low; a taken request passes
// through the input register, then the result register. All filter work for a request
// sits between those two registers. Synchronous reset clears the handshake and
// filter state; offsets reset to zero. A stalled result holds and the input
// register still takes one more request before in_stall rises.
module dual_sensor_median_ema_filter (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  dsmef_pkg::req_t                      in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output dsmef_pkg::res_t                      out_data,
  input  logic                                 cfg_we,
  input  logic [dsmef_pkg::IDX_W-1:0]          cfg_index,
  input  logic signed [dsmef_pkg::OFS_W-1:0]   cfg_data
);
  import dsmef_pkg::*;

  logic signed [OFS_W-1:0] ofs [NCHAN];

  req_t              req;
  logic              req_full;
  logic              move;
  logic              start;
  logic [1:0]        vflag_next;
  logic [TIME_W-1:0] last_valid, last_valid_next;
  logic              any_next;
  chan_ctl_t         ctl_bottom, ctl_top;
  logic signed [VALUE_W-1:0] sm_bt, sm_bh, sm_tt, sm_th;
  res_t              res_next;

  // offsets
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NCHAN; i++) ofs[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BOTTOM_TEMP_OFS: ofs[0] <= cfg_data;
        REG_BOTTOM_HUM_OFS:  ofs[1] <= cfg_data;
        REG_TOP_TEMP_OFS:    ofs[2] <= cfg_data;
        REG_TOP_HUM_OFS:     ofs[3] <= cfg_data;
        default:             ofs[0] <= ofs[0];
      endcase
    end
  end

  // handshake
  assign move     = req_full && (!out_valid || !out_stall);
  assign in_stall = req_full && !move;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      req_full <= 1'b1;
    end else if (move) begin
      req_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req <= in_data;
    end
  end

  assign start = (req.mode == MODE_BEGIN);

  assign ctl_bottom = '{commit: move, start: start, ok: req.bottom_ok};
  assign ctl_top    = '{commit: move, start: start, ok: req.top_ok};

  dsmef_chan u_bt (.clk, .rst, .ctl(ctl_bottom), .sample(req.bottom_temp),
                   .offset(ofs[0]), .smooth(sm_bt));
  dsmef_chan u_bh (.clk, .rst, .ctl(ctl_bottom), .sample(req.bottom_humidity),
                   .offset(ofs[1]), .smooth(sm_bh));
  dsmef_chan u_tt (.clk, .rst, .ctl(ctl_top), .sample(req.top_temp),
                   .offset(ofs[2]), .smooth(sm_tt));
  dsmef_chan u_th (.clk, .rst, .ctl(ctl_top), .sample(req.top_humidity),
                   .offset(ofs[3]), .smooth(sm_th));

  always_comb begin
    vflag_next      = start ? 2'b00 : {req.top_ok, req.bottom_ok};
    any_next        = |vflag_next;
    last_valid_next = (start || any_next) ? req.now_ms : last_valid;

    res_next.bottom_temp_smooth     = sm_bt;
    res_next.bottom_humidity_smooth = sm_bh;
    res_next.bottom_valid           = vflag_next[0];
    res_next.top_temp_smooth        = sm_tt;
    res_next.top_humidity_smooth    = sm_th;
    res_next.top_valid              = vflag_next[1];
    if (vflag_next[0]) begin
      res_next.control_source = SRC_BOTTOM;
    end else if (vflag_next[1]) begin
      res_next.control_source = SRC_TOP;
    end else begin
      res_next.control_source = SRC_NONE;
    end
    res_next.invalid_duration_ms = any_next ? '0 : req.now_ms - last_valid_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_valid <= '0;
    end else if (move) begin
      last_valid <= last_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_data <= res_next;
    end
  end

  // bottom drives control exactly when it is valid
  a_src_bottom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.control_source == SRC_BOTTOM) == out_data.bottom_valid))
    else $error("control source disagrees with bottom valid");

  // duration is zero whenever a sensor is valid
  a_dur_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.bottom_valid || out_data.top_valid)
      |-> (out_data.invalid_duration_ms == '0))
    else $error("nonzero invalid duration with a valid sensor");

  // a processed request always lands in the result register
  a_move_out: assert property (@(posedge clk) disable iff (rst)
    move |=> out_valid)
    else $error("processed request lost");

  // stall only while the input register holds a request
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> req_full)
    else $error("stall without a held request");

endmodule

FILE: test/tb_dual_sensor_median_ema_filter.sv
// Self-checking testbench for the dual sensor median and EMA filter.
`timescale 1ns / 1ps

module tb_dual_sensor_median_ema_filter;
  import dsmef_pkg::*;

  localparam int CLK_PERIOD  = 12;
  localparam int CYCLE_LIMIT = 500000;
  localparam int MAX_REPORTS = 10;
  localparam logic [IDX_W-1:0] OFS_REGS [NCHAN] =
    '{REG_BOTTOM_TEMP_OFS, REG_BOTTOM_HUM_OFS, REG_TOP_TEMP_OFS, REG_TOP_HUM_OFS};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  res_t out_data;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic signed [OFS_W-1:0] cfg_data = '0;

  dual_sensor_median_ema_filter dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // predictor state, channels: 0 bottom temp, 1 bottom hum, 2 top temp, 3 top hum
  int samp [NCHAN][3];
  int wr_pos [NCHAN];
  int fill_cnt [NCHAN];
  bit ema_live [NCHAN];
  int ema [NCHAN];
  bit sensor_ok [2];
  logic [TIME_W-1:0] last_good_ms;
  int ofs [NCHAN];

  req_t req_backlog [$];
  res_t res_due_q [$];
  int fail_count = 0;
  int unsigned cycle_count = 0;
  int burst_left = 0;
  int gap_left = 0;

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int median3(int a, int b, int c);
    int lo, hi;
    lo = (a < b) ? a : b;
    hi = (a > b) ? a : b;
    hi = (hi < c) ? hi : c;
    return (lo > hi) ? lo : hi;
  endfunction

  function automatic void reset_channel(int ch, bit clear_avg);
    wr_pos[ch] = 0;
    fill_cnt[ch] = 0;
    ema_live[ch] = 1'b0;
    if (clear_avg) ema[ch] = 0;
  endfunction

  function automatic void push_channel(int ch, int v);
    int med;
    samp[ch][wr_pos[ch]] = v;
    wr_pos[ch] = (wr_pos[ch] + 1) % 3;
    if (fill_cnt[ch] < 3) fill_cnt[ch]++;
    // newest sample stands in for the median until the window is full
    med = (fill_cnt[ch] < 3) ? v : median3(samp[ch][0], samp[ch][1], samp[ch][2]);
    if (!ema_live[ch]) begin
      ema[ch] = med;
      ema_live[ch] = 1'b1;
    end else begin
      ema[ch] = (77 * med + 179 * ema[ch] + 128) >>> 8;
    end
  endfunction

  function automatic void update_sensor(int s, logic ok, logic signed [VALUE_W-1:0] t,
                                        logic signed [VALUE_W-1:0] rh);
    if (ok) begin
      push_channel(2 * s, clamp16(int'(t) + ofs[2 * s]));
      push_channel(2 * s + 1, clamp16(int'(rh) + ofs[2 * s + 1]));
      sensor_ok[s] = 1'b1;
    end else begin
      sensor_ok[s] = 1'b0;
      reset_channel(2 * s, 1'b0);
      reset_channel(2 * s + 1, 1'b0);
    end
  endfunction

  function automatic res_t predict_smoothing(req_t r);
    res_t o;
    if (r.mode == MODE_BEGIN) begin
      for (int i = 0; i < NCHAN; i++) reset_channel(i, 1'b1);
      sensor_ok[0] = 1'b0;
      sensor_ok[1] = 1'b0;
      last_good_ms = r.now_ms;
    end else begin
      update_sensor(0, r.bottom_ok, r.bottom_temp, r.bottom_humidity);
      update_sensor(1, r.top_ok, r.top_temp, r.top_humidity);
      if (sensor_ok[0] || sensor_ok[1]) last_good_ms = r.now_ms;
    end
    o.bottom_temp_smooth     = VALUE_W'(ema[0]);
    o.bottom_humidity_smooth = VALUE_W'(ema[1]);
    o.bottom_valid           = sensor_ok[0];
    o.top_temp_smooth        = VALUE_W'(ema[2]);
    o.top_humidity_smooth    = VALUE_W'(ema[3]);
    o.top_valid              = sensor_ok[1];
    o.control_source = sensor_ok[0] ? SRC_BOTTOM : (sensor_ok[1] ? SRC_TOP : SRC_NONE);
    o.invalid_duration_ms = (sensor_ok[0] || sensor_ok[1]) ? '0 : r.now_ms - last_good_ms;
    return o;
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) note_failure($sformatf("%s expected %0h got %0h", name, want, got));
  endtask

  function automatic req_t make_req(logic md, logic [TIME_W-1:0] now, logic bok, int bt,
                                    int bh, logic tok, int tt, int th);
    req_t r;
    r.mode            = md;
    r.now_ms          = now;
    r.bottom_ok       = bok;
    r.bottom_temp     = VALUE_W'(bt);
    r.bottom_humidity = VALUE_W'(bh);
    r.top_ok          = tok;
    r.top_temp        = VALUE_W'(tt);
    r.top_humidity    = VALUE_W'(th);
    return r;
  endfunction

  // request driver: bursts of random length with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) res_due_q.push_back(predict_smoothing(in_data));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          in_data <= req_backlog.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            case ($urandom_range(0, 7))
              0: begin
                burst_left = 60;
                gap_left = 0;
              end
              7: begin
                burst_left = $urandom_range(1, 24);
                gap_left = $urandom_range(10, 25);
              end
              default: begin
                burst_left = $urandom_range(1, 24);
                gap_left = $urandom_range(0, 6);
              end
            endcase
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor; stall pattern rotates through four modes
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (res_due_q.size() == 0) begin
          note_failure("result with no request outstanding");
        end else begin
          res_t want;
          want = res_due_q.pop_front();
          check_field("bottom_temp_smooth", want.bottom_temp_smooth,
                      out_data.bottom_temp_smooth);
          check_field("bottom_humidity_smooth", want.bottom_humidity_smooth,
                      out_data.bottom_humidity_smooth);
          check_field("bottom_valid", want.bottom_valid, out_data.bottom_valid);
          check_field("top_temp_smooth", want.top_temp_smooth, out_data.top_temp_smooth);
          check_field("top_humidity_smooth", want.top_humidity_smooth,
                      out_data.top_humidity_smooth);
          check_field("top_valid", want.top_valid, out_data.top_valid);
          check_field("control_source", want.control_source, out_data.control_source);
          check_field("invalid_duration_ms", want.invalid_duration_ms,
                      out_data.invalid_duration_ms);
        end
      end
      case ((cycle_count >> 8) % 4)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ((cycle_count % 7) < 3);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               res_due_q.size());
      $display("tb_dual_sensor_median_ema_filter NOT OK");
      $finish;
    end
  end

  task automatic wait_drained();
    do @(negedge clk); while (req_backlog.size() != 0 || in_valid || res_due_q.size() != 0);
  endtask

  task automatic write_offsets(int v0, int v1, int v2, int v3);
    int vals [NCHAN];
    vals = '{v0, v1, v2, v3};
    for (int i = 0; i < NCHAN; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= OFS_REGS[i];
      cfg_data <= OFS_W'(vals[i]);
      ofs[i] = vals[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic int pick_base();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 3) return 32767 - int'($urandom_range(0, 300));
    if (sel < 6) return -32768 + int'($urandom_range(0, 300));
    return int'($urandom_range(0, 12000)) - 2000;
  endfunction

  function automatic int pick_ok_rate();
    case ($urandom_range(0, 4))
      0, 1: return 100;
      2: return 90;
      3: return 60;
      default: return 0;
    endcase
  endfunction

  function automatic int sensor_reading(int base);
    // occasional spike so the median has something to reject
    if ($urandom_range(0, 99) < 6) return int'($urandom);
    return clamp16(base + int'($urandom_range(0, 100)) - 50);
  endfunction

  task automatic queue_random_requests(int count);
    int made, n, len, p_b, p_t;
    int base [NCHAN];
    logic [TIME_W-1:0] t;
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 99) < 15) begin
        n = $urandom_range(1, 5);
        for (int k = 0; k < n; k++)
          req_backlog.push_back(make_req(1'($urandom_range(0, 1)), $urandom,
            1'($urandom_range(0, 1)), $urandom, $urandom, 1'($urandom_range(0, 1)),
            $urandom, $urandom));
        made += n;
      end else begin
        case ($urandom_range(0, 3))
          0: t = $urandom;
          1: t = 32'hFFFF_FFFF - $urandom_range(0, 20000);
          default: t = $urandom_range(0, 100000);
        endcase
        for (int j = 0; j < NCHAN; j++) base[j] = pick_base();
        p_b = pick_ok_rate();
        p_t = pick_ok_rate();
        if ($urandom_range(0, 4) != 0) begin
          req_backlog.push_back(make_req(MODE_BEGIN, t, 1'($urandom_range(0, 1)), $urandom,
            $urandom, 1'($urandom_range(0, 1)), $urandom, $urandom));
          made++;
        end
        len = $urandom_range(3, 30);
        for (int k = 0; k < len; k++) begin
          t += ($urandom_range(0, 19) == 0) ? $urandom_range(0, 100000)
                                            : $urandom_range(800, 1200);
          req_backlog.push_back(make_req(MODE_UPDATE, t, $urandom_range(0, 99) < p_b,
            sensor_reading(base[0]), sensor_reading(base[1]), $urandom_range(0, 99) < p_t,
            sensor_reading(base[2]), sensor_reading(base[3])));
          for (int j = 0; j < NCHAN; j++)
            base[j] = clamp16(base[j] + int'($urandom_range(0, 40)) - 20);
        end
        made += len;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < NCHAN; i++) begin
      ofs[i] = 0;
      reset_channel(i, 1'b1);
    end
    sensor_ok[0] = 1'b0;
    sensor_ok[1] = 1'b0;
    last_good_ms = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset offsets: invalid before any begin, window fill, spike, wrap
    req_backlog.push_back(make_req(MODE_UPDATE, 5, 0, 100, 200, 0, 300, 400));
    req_backlog.push_back(make_req(MODE_BEGIN, 100, 1, 2500, 4000, 1, 1800, 3000));
    req_backlog.push_back(make_req(MODE_UPDATE, 1100, 1, 2500, 4000, 0, 1800, 3000));
    req_backlog.push_back(make_req(MODE_UPDATE, 2100, 1, 2600, 4100, 1, 1800, 3000));
    req_backlog.push_back(make_req(MODE_UPDATE, 3100, 1, 9000, 4200, 1, 1850, 3050));
    req_backlog.push_back(make_req(MODE_UPDATE, 4100, 0, 2700, 4300, 1, 1900, 3100));
    req_backlog.push_back(make_req(MODE_UPDATE, 5100, 0, 2700, 4300, 0, 1900, 3100));
    req_backlog.push_back(make_req(MODE_UPDATE, 32'hFFFF_FFF0, 0, 0, 0, 0, 0, 0));
    req_backlog.push_back(make_req(MODE_BEGIN, 32'hFFFF_FF00, 0, 0, 0, 0, 0, 0));
    req_backlog.push_back(make_req(MODE_UPDATE, 32'h0000_0100, 0, 0, 0, 0, 0, 0));
    req_backlog.push_back(make_req(MODE_UPDATE, 32'h0000_0200, 1, 32767, 32767, 1,
                                   -32768, -32768));
    req_backlog.push_back(make_req(MODE_BEGIN, 0, 1, 0, 0, 1, 0, 0));
    wait_drained();

    // extreme offsets: saturation at both ends and full-scale swings
    write_offsets(1000, 1000, -1000, -1000);
    req_backlog.push_back(make_req(MODE_UPDATE, 10, 1, 32767, 32000, 1, -32768, -32000));
    req_backlog.push_back(make_req(MODE_UPDATE, 20, 1, 32767, 32000, 1, -32768, -32000));
    req_backlog.push_back(make_req(MODE_UPDATE, 30, 1, -32768, -32768, 1, 32767, 32767));
    req_backlog.push_back(make_req(MODE_UPDATE, 40, 1, -32768, -32768, 1, 32767, 32767));
    req_backlog.push_back(make_req(MODE_UPDATE, 50, 1, 'h5555, 'hAAAA, 1, 'hAAAA, 'h5555));
    req_backlog.push_back(make_req(MODE_UPDATE, 60, 0, 'hAAAA, 'h5555, 1, 'h5555, 'hAAAA));
    req_backlog.push_back(make_req(MODE_BEGIN, 32'hFFFF_FFFF, 1, 0, 0, 1, 0, 0));
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_offsets(1000, 1000, 1000, 1000);
        1: write_offsets(-1000, -1000, -1000, -1000);
        2: write_offsets(0, 0, 0, 0);
        default: write_offsets(int'($urandom_range(0, 2000)) - 1000,
                               int'($urandom_range(0, 2000)) - 1000,
                               int'($urandom_range(0, 2000)) - 1000,
                               int'($urandom_range(0, 2000)) - 1000);
      endcase
      queue_random_requests(260);
      wait_drained();
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    if (res_due_q.size() != 0) note_failure("results still outstanding at end of run");
    if (fail_count == 0) begin
      $display("tb_dual_sensor_median_ema_filter OK");
    end else begin
      $display("tb_dual_sensor_median_ema_filter NOT OK");
    end
    $finish;
  end

endmodule
